FILE: design/dmm_pkg.sv
// Shared types and constants for the dense matrix multiply block.
package dmm_pkg;

	localparam int MAX_ORDER = 8;
	localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int ORDER_W   = 4;
	localparam int IDX_W     = $clog2(MAX_ORDER);
	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int SUM_W     = 35;
	localparam int Q_DEPTH   = 4;
	localparam int QPTR_W    = $clog2(Q_DEPTH);
	localparam int QCNT_W    = QPTR_W + 1;

	localparam logic OP_A = 1'b0;
	localparam logic OP_B = 1'b1;

	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(MAX_ORDER);

	typedef struct packed {
		logic                     op;
		logic signed [ELEM_W-1:0] element;
	} in_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] product_element;
		logic                    last;
	} out_word_t;

	// Command passed from front to back: one store, optionally starting the product.
	typedef struct packed {
		logic                     is_b;
		logic [ADDR_W-1:0]        addr;
		logic signed [ELEM_W-1:0] data;
		logic                     go;
	} cmd_t;

	// Order in use: 0 acts as 1, anything above MAX_ORDER acts as MAX_ORDER.
	function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] raw);
		logic [ORDER_W-1:0] n;
		n = raw;
		if (raw == '0)
			n = ORDER_W'(1);
		else if (raw > ORDER_W'(MAX_ORDER))
			n = ORDER_W'(MAX_ORDER);
		return n;
	endfunction

endpackage

FILE: design/dense_matrix_multiply.sv
// Dense square matrix multiply C = A x B, top level.
//
// Input channel (in_valid/in_ready/in_word): each word carries op and one
// signed 16-bit element; op selects A or B, elements arrive row-major.
// Words for a matrix that is already full are taken and dropped. The word
// that completes both matrices starts the product.
// Output channel (out_valid/out_ready/out_word): the n*n elements of C in
// row-major order as exact 35-bit sums, last set on the final one.
// cfg_we/cfg_data write the order n (0 acts as 1, above 8 acts as 8) and
// restart loading; write it only while the block is idle.
// Loads drain through a 4-word queue at one word per cycle while the back
// end is loading; it takes none while a product runs. One shared
// multiply-accumulate unit does n steps per product element and starts
// the next element while earlier ones are still in its pipeline. A
// stalled receiver holds up to two results; the unit then pauses. The
// queue fills while the unit runs or pauses, after which in_ready drops.
// Reset: order 8, both load counts zero, stores hold no defined data.
module dense_matrix_multiply import dmm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [ORDER_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output out_word_t          out_word
);

	logic               q_push, q_full, q_pop, q_valid;
	cmd_t               push_cmd, pop_cmd;
	logic [ORDER_W-1:0] order;

	dmm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd),
		.order    (order)
	);

	dmm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_cmd  (pop_cmd)
	);

	dmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order),
		.q_valid   (q_valid),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

FILE: design/dmm_front.sv
// Front end: order register, load counters and classification of input words.
module dmm_front import dmm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [ORDER_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_word,
	input  logic               q_full,
	output logic               q_push,
	output cmd_t               q_cmd,
	output logic [ORDER_W-1:0] order
);

	logic [ORDER_W-1:0] matrix_size_q;
	logic [CNT_W-1:0]   count_a_q;
	logic [CNT_W-1:0]   count_b_q;
	logic [CNT_W-1:0]   total;
	logic               a_full;
	logic               b_full;
	logic               accept;

	assign order    = clamp_order(matrix_size_q);
	assign total    = CNT_W'(order) * CNT_W'(order);
	assign a_full   = count_a_q >= total;
	assign b_full   = count_b_q >= total;
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Words for a matrix that is already full are dropped here.
	always_comb begin
		q_push     = 1'b0;
		q_cmd.is_b = in_word.op;
		q_cmd.data = in_word.element;
		q_cmd.addr = count_a_q[ADDR_W-1:0];
		q_cmd.go   = 1'b0;
		if (in_word.op == OP_A) begin
			q_push   = accept && !a_full;
			q_cmd.go = (count_a_q + CNT_W'(1) == total) && b_full;
		end else begin
			q_cmd.addr = count_b_q[ADDR_W-1:0];
			q_push     = accept && !b_full;
			q_cmd.go   = (count_b_q + CNT_W'(1) == total) && a_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= ORDER_RESET;
			count_a_q     <= '0;
			count_b_q     <= '0;
		end else if (cfg_we) begin
			matrix_size_q <= cfg_data;
			count_a_q     <= '0;
			count_b_q     <= '0;
		end else if (q_push) begin
			if (q_cmd.go) begin
				count_a_q <= '0;
				count_b_q <= '0;
			end else if (q_cmd.is_b == OP_A) begin
				count_a_q <= count_a_q + CNT_W'(1);
			end else begin
				count_b_q <= count_b_q + CNT_W'(1);
			end
		end
	end

endmodule

FILE: design/dmm_queue.sv
// Short command queue between front and back.
module dmm_queue import dmm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_cmd
);

	cmd_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = cnt_q == QCNT_W'(Q_DEPTH);
	assign valid   = cnt_q != '0;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

FILE: design/dmm_back.sv
// Back end: matrix stores, multiply-accumulate pipeline and output buffer.
module dmm_back import dmm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ORDER_W-1:0] order,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output out_word_t          out_word
);

	localparam logic BS_LOAD = 1'b0;
	localparam logic BS_RUN  = 1'b1;

	logic signed [ELEM_W-1:0] store_a [DEPTH];
	logic signed [ELEM_W-1:0] store_b [DEPTH];

	logic              state_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [ADDR_W-1:0] row_base_q, a_addr_q, b_addr_q;
	logic [1:0]        outst_q;

	logic [IDX_W-1:0]  nm1;
	logic [ADDR_W-1:0] step;
	logic              end_k, end_j, end_i;
	logic              issue;
	logic              out_take;

	logic                     valid_s1, first_s1, end_s1, last_s1;
	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic                     valid_s2, first_s2, end_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum;

	out_word_t  ofifo_q [2];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;
	logic       opush;

	assign nm1   = IDX_W'(order - ORDER_W'(1));
	assign step  = ADDR_W'(order);
	assign end_k = k_q == nm1;
	assign end_j = j_q == nm1;
	assign end_i = i_q == nm1;

	assign q_pop    = (state_q == BS_LOAD) && q_valid;
	assign out_take = out_valid && out_ready;
	// A new element starts only while at most one earlier result is unclaimed.
	assign issue    = (state_q == BS_RUN) && ((k_q != '0) || (outst_q != 2'd2));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_cmd.is_b == OP_B)
				store_b[q_cmd.addr] <= q_cmd.data;
			else
				store_a[q_cmd.addr] <= q_cmd.data;
		end
		if (issue) begin
			a_s1 <= store_a[a_addr_q];
			b_s1 <= store_b[b_addr_q];
		end
	end

	// Address walk: A along row i, B down column j.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BS_LOAD;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
		end else if (state_q == BS_LOAD) begin
			if (q_pop && q_cmd.go) begin
				state_q    <= BS_RUN;
				i_q        <= '0;
				j_q        <= '0;
				k_q        <= '0;
				row_base_q <= '0;
				a_addr_q   <= '0;
				b_addr_q   <= '0;
			end
		end else if (issue) begin
			if (!end_k) begin
				k_q      <= k_q + IDX_W'(1);
				a_addr_q <= a_addr_q + ADDR_W'(1);
				b_addr_q <= b_addr_q + step;
			end else begin
				k_q <= '0;
				if (!end_j) begin
					j_q      <= j_q + IDX_W'(1);
					a_addr_q <= row_base_q;
					b_addr_q <= ADDR_W'(j_q) + ADDR_W'(1);
				end else begin
					j_q <= '0;
					if (end_i) begin
						state_q <= BS_LOAD;
					end else begin
						i_q        <= i_q + IDX_W'(1);
						row_base_q <= row_base_q + step;
						a_addr_q   <= row_base_q + step;
						b_addr_q   <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			outst_q  <= outst_q + 2'(issue && (k_q == '0)) - 2'(out_take);
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			first_s1 <= k_q == '0;
			end_s1   <= end_k;
			last_s1  <= end_k && end_j && end_i;
		end
		if (valid_s1) begin
			prod_s2  <= a_s1 * b_s1;
			first_s2 <= first_s1;
			end_s2   <= end_s1;
			last_s2  <= last_s1;
		end
		if (valid_s2)
			acc_q <= sum;
	end

	assign sum   = (first_s2 ? SUM_W'(0) : acc_q) + SUM_W'(prod_s2);
	assign opush = valid_s2 && end_s2;

	always_ff @(posedge clk) begin
		if (opush) begin
			ofifo_q[owr_q].product_element <= sum;
			ofifo_q[owr_q].last            <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (opush)
				owr_q <= !owr_q;
			if (out_take)
				ord_q <= !ord_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(out_take);
		end
	end

	assign out_valid = ocnt_q != '0;
	assign out_word  = ofifo_q[ord_q];

endmodule
